@@ hdl/sao_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simplex alignment optimizer package
// Shared constants, register indexes, interface structs and saturation helper.
// ----------------------------------------------------------------------------
package sao_pkg;

   localparam int FRACTION_BITS_DEFAULT  = 16;
   localparam int ITERATION_BITS_DEFAULT = 10;
   localparam int CFG_BITS               = 31;
   localparam int CSR_INDEX_BITS         = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DECENTER_GAIN  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TILT_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEFOCUS_WEIGHT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STOP_TOLERANCE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INITIAL_STEP   = 3'd4;

   // Per-job input values seen by the merit unit.
   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] tilt;
      logic signed [31:0] focus;
   } job_type;

   // Merit evaluation request: start strobe and the move vertex.
   typedef struct packed {
      logic               start;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vf;
   } merit_req_type;

   // Merit evaluation status.
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [30:0] merit;
   } merit_rsp_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

@@ hdl/sao_merit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spot merit unit
// Evaluates sqrt(latx^2 + laty^2 + (weight*focus)^2) with one shared
// multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
module sao_merit #(
   parameter int FRACTION_BITS = sao_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sao_pkg::merit_req_type mreq,
   input  sao_pkg::job_type       job,
   input  logic [30:0]            decenter_gain,
   input  logic [30:0]            tilt_gain,
   input  logic [30:0]            defocus_weight,
   output sao_pkg::merit_rsp_type mrsp
);

   typedef enum logic [2:0] {
      M_IDLE = 3'b001,
      M_MUL  = 3'b010,
      M_SQRT = 3'b100
   } mstate_type;

   mstate_type         state_ff;
   logic [2:0]         step_ff;
   logic signed [31:0] x_ff, y_ff, f_ff;
   logic signed [31:0] lx_ff, ly_ff, lf_ff;
   logic signed [63:0] acc_ff;
   logic signed [65:0] prod_ff;
   logic [63:0]        sum_ff;
   logic [63:0]        n_ff, res_ff, bit_ff;
   logic [4:0]         cnt_ff;
   logic [30:0]        merit_ff;
   logic               done_ff;

   logic signed [32:0] op_a, op_b;
   logic signed [65:0] prod_in;
   logic signed [63:0] lat_sum;
   logic [63:0]        trial, n_in, res_in;
   logic               take;

   // Operand select for the shared multiplier, one product per step.
   always_comb begin
      unique case (step_ff)
         3'd0: begin op_a = $signed({2'b00, decenter_gain});  op_b = {x_ff[31], x_ff};   end
         3'd1: begin op_a = $signed({2'b00, tilt_gain});      op_b = {job.tilt[31], job.tilt}; end
         3'd2: begin op_a = $signed({2'b00, decenter_gain});  op_b = {y_ff[31], y_ff};   end
         3'd3: begin op_a = $signed({2'b00, defocus_weight}); op_b = {f_ff[31], f_ff};   end
         3'd4: begin op_a = {lx_ff[31], lx_ff}; op_b = {lx_ff[31], lx_ff}; end
         3'd5: begin op_a = {ly_ff[31], ly_ff}; op_b = {ly_ff[31], ly_ff}; end
         3'd6: begin op_a = {lf_ff[31], lf_ff}; op_b = {lf_ff[31], lf_ff}; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_in = op_a * op_b;
   assign lat_sum = acc_ff + prod_ff[63:0];

   // One square-root digit per cycle.
   assign trial  = res_ff + bit_ff;
   assign take   = (n_ff >= trial);
   assign n_in   = take ? (n_ff - trial) : n_ff;
   assign res_in = take ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= M_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            M_IDLE: begin
               if (mreq.start) begin
                  x_ff     <= sao_pkg::sat32(66'($signed(job.ox)) + 66'($signed(mreq.vx)));
                  y_ff     <= sao_pkg::sat32(66'($signed(job.oy)) + 66'($signed(mreq.vy)));
                  f_ff     <= sao_pkg::sat32(66'($signed(job.focus)) + 66'($signed(mreq.vf)));
                  step_ff  <= '0;
                  state_ff <= M_MUL;
               end
            end
            M_MUL: begin
               step_ff <= step_ff + 3'd1;
               case (step_ff)
                  3'd1: acc_ff <= prod_ff[63:0];
                  3'd2: lx_ff  <= sao_pkg::sat32(66'(lat_sum >>> FRACTION_BITS));
                  3'd3: ly_ff  <= sao_pkg::sat32(prod_ff >>> FRACTION_BITS);
                  3'd4: lf_ff  <= sao_pkg::sat32(prod_ff >>> FRACTION_BITS);
                  3'd5: sum_ff <= prod_ff[63:0];
                  3'd6: sum_ff <= sum_ff + prod_ff[63:0];
                  3'd7: begin
                     n_ff     <= sum_ff + prod_ff[63:0];
                     res_ff   <= '0;
                     bit_ff   <= 64'd1 << 62;
                     cnt_ff   <= '0;
                     state_ff <= M_SQRT;
                  end
                  default: ;
               endcase
            end
            M_SQRT: begin
               n_ff   <= n_in;
               res_ff <= res_in;
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  merit_ff <= (res_in > 64'h7fffffff) ? 31'h7fffffff : res_in[30:0];
                  done_ff  <= 1'b1;
                  state_ff <= M_IDLE;
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign mrsp.busy  = (state_ff != M_IDLE);
   assign mrsp.done  = done_ff;
   assign mrsp.merit = merit_ff;

endmodule

@@ hdl/simplex_alignment_optimizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simplex alignment optimizer
// Three-axis Nelder-Mead search for the compensating move of an assembly.
// ----------------------------------------------------------------------------
// Each request transaction is one alignment job; it yields exactly one response
// transaction once the search ends. The block takes one job at a time and holds
// req_tready low until the job's result has been loaded into the response
// register, so a new job may start while the previous result still waits. All
// merit arithmetic runs through one merit unit with a single shared multiplier
// (eight product steps) and a bit-serial square root (32 steps); the centroid
// division by three has its own multiplier. A job sets up with five merit
// evaluations, then each iteration orders the vertices (S_SORT), forms the
// centroid in two states per axis (S_CEN_LD, S_CEN) with a reciprocal
// multiplication by one third, and runs one to five merit evaluations.
// ----------------------------------------------------------------------------
module simplex_alignment_optimizer #(
   parameter int FRACTION_BITS  = sao_pkg::FRACTION_BITS_DEFAULT,
   parameter int ITERATION_BITS = sao_pkg::ITERATION_BITS_DEFAULT,
   localparam int REQ_FIELDS_W = 4 * 32 + ITERATION_BITS,
   localparam int REQ_W = ((REQ_FIELDS_W + 7) / 8) * 8,
   localparam int RSP_FIELDS_W = 2 * 31 + 3 * 32 + ITERATION_BITS + 1,
   localparam int RSP_W = ((RSP_FIELDS_W + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // offset_x, offset_y, tilt_error, focus_error, iteration_limit
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,
   // merit_start, merit_best, move_x, move_y, move_focus, iterations_used,
   // improved
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_W-1:0]                   rsp_tdata,
   input  logic                               csr_we,
   input  logic [sao_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sao_pkg::CFG_BITS-1:0]       csr_data
);

   localparam logic [30:0] DG_RESET   = 31'(64'd1 << FRACTION_BITS);
   localparam logic [30:0] W_RESET    = 31'((64'd6 * (64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);
   localparam logic [30:0] STEP_RESET = 31'(64'd20 << FRACTION_BITS);
   // ceil(2^35 / 3): exact floor division by three for magnitudes below 2^33.
   localparam logic [33:0] THIRD_RECIP = 34'h2AAAAAAAB;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_INIT   = 15'b000000000000010,
      S_INIT_W = 15'b000000000000100,
      S_SORT   = 15'b000000000001000,
      S_CEN_LD = 15'b000000000010000,
      S_CEN    = 15'b000000000100000,
      S_REF    = 15'b000000001000000,
      S_REF_W  = 15'b000000010000000,
      S_EXP    = 15'b000000100000000,
      S_EXP_W  = 15'b000001000000000,
      S_CON    = 15'b000010000000000,
      S_CON_W  = 15'b000100000000000,
      S_SHR    = 15'b001000000000000,
      S_SHR_W  = 15'b010000000000000,
      S_OUT    = 15'b100000000000000
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [30:0] dg_ff, tg_ff, w_ff, tol_ff, istep_ff;

   // Job and simplex state.
   sao_pkg::job_type          job_ff;
   logic [ITERATION_BITS-1:0] limit_ff, it_ff;
   logic [2:0]                vi_ff, si_ff;
   logic signed [31:0]        s_ff [4][3];
   logic [30:0]               m0_ff, fr_ff;
   logic [30:0]               fv_ff [4];
   logic [1:0]                lo_ff, hi_ff, hi2_ff, k_ff;
   logic signed [31:0]        cen_ff [3];

   // Centroid magnitude and sign, divided by three in the next cycle.
   logic [32:0] dn_ff;
   logic        dneg_ff;

   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   sao_pkg::merit_req_type mreq;
   sao_pkg::merit_rsp_type mrsp;

   logic [1:0]         rank [4];
   logic [1:0]         lo_c, hi_c, hi2_c;
   logic signed [33:0] sum_c, mag_c;
   logic [66:0]        third_prod;
   logic [31:0]        q_c;
   logic signed [33:0] cen_c;
   logic signed [31:0] xr [3], xe [3], xc [3], xs [3];
   logic signed [31:0] mv [3];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Stable ordering by merit: equal merits keep vertex number order.
   always_comb begin
      lo_c  = '0;
      hi_c  = '0;
      hi2_c = '0;
      for (int i = 0; i < 4; i++) begin
         rank[i] = '0;
         for (int j = 0; j < 4; j++) begin
            if (j != i && (fv_ff[j] < fv_ff[i] || (fv_ff[j] == fv_ff[i] && j < i))) begin
               rank[i] = rank[i] + 2'd1;
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         case (rank[i])
            2'd0: lo_c  = 2'(i);
            2'd2: hi2_c = 2'(i);
            2'd3: hi_c  = 2'(i);
            default: ;
         endcase
      end
   end

   // Sum of the three coordinates other than the worst vertex's.
   always_comb begin
      sum_c = '0;
      for (int i = 0; i < 4; i++) begin
         if (2'(i) != hi_ff) begin
            sum_c = sum_c + 34'(s_ff[i][k_ff]);
         end
      end
      mag_c = (sum_c < 0) ? -sum_c : sum_c;
   end

   // Division of the magnitude by three, truncated toward zero after the sign.
   assign third_prod = {34'b0, dn_ff} * {33'b0, THIRD_RECIP};
   assign q_c        = third_prod[66:35];
   assign cen_c      = dneg_ff ? -$signed({2'b00, q_c}) : $signed({2'b00, q_c});

   // Candidate vertices: reflection, expansion, contraction and shrink.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xr[k] = sao_pkg::sat32(66'(cen_ff[k]) + 66'(cen_ff[k]) - 66'(s_ff[hi_ff][k]));
         xe[k] = sao_pkg::sat32(66'(cen_ff[k]) + 66'(cen_ff[k]) + 66'(cen_ff[k])
                                - 66'(s_ff[hi_ff][k]) - 66'(s_ff[hi_ff][k]));
         xc[k] = 32'((34'(cen_ff[k]) + 34'(s_ff[hi_ff][k])) >>> 1);
         xs[k] = 32'((34'(s_ff[lo_ff][k]) + 34'(s_ff[si_ff[1:0]][k])) >>> 1);
      end
   end

   // Vertex handed to the merit unit.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         unique case (state_ff)
            S_INIT:  mv[k] = (vi_ff == 3'd0) ? 32'sd0 : s_ff[vi_ff[1:0] - 2'd1][k];
            S_REF:   mv[k] = xr[k];
            S_EXP:   mv[k] = xe[k];
            S_CON:   mv[k] = xc[k];
            S_SHR:   mv[k] = xs[k];
            default: mv[k] = 32'sd0;
         endcase
      end
   end

   assign mreq.start = (state_ff == S_INIT) || (state_ff == S_REF) || (state_ff == S_EXP)
                    || (state_ff == S_CON)
                    || (state_ff == S_SHR && si_ff != 3'd4 && si_ff[1:0] != lo_ff);
   assign mreq.vx = mv[0];
   assign mreq.vy = mv[1];
   assign mreq.vf = mv[2];

   sao_merit #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_merit (
      .clock          (clock),
      .reset          (reset),
      .mreq           (mreq),
      .job            (job_ff),
      .decenter_gain  (dg_ff),
      .tilt_gain      (tg_ff),
      .defocus_weight (w_ff),
      .mrsp           (mrsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dg_ff        <= DG_RESET;
         tg_ff        <= DG_RESET;
         w_ff         <= W_RESET;
         tol_ff       <= 31'd1;
         istep_ff     <= STEP_RESET;
         it_ff        <= '0;
         limit_ff     <= '0;
         vi_ff        <= '0;
         si_ff        <= '0;
         k_ff         <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               sao_pkg::REG_DECENTER_GAIN:  dg_ff    <= csr_data;
               sao_pkg::REG_TILT_GAIN:      tg_ff    <= csr_data;
               sao_pkg::REG_DEFOCUS_WEIGHT: w_ff     <= csr_data;
               sao_pkg::REG_STOP_TOLERANCE: tol_ff   <= csr_data;
               sao_pkg::REG_INITIAL_STEP:   istep_ff <= csr_data;
               default: ;
            endcase
         end

         // The output state reloads the register itself when it is taken.
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  job_ff.ox    <= req_tdata[31:0];
                  job_ff.oy    <= req_tdata[63:32];
                  job_ff.tilt  <= req_tdata[95:64];
                  job_ff.focus <= req_tdata[127:96];
                  limit_ff     <= req_tdata[128 +: ITERATION_BITS];
                  it_ff        <= '0;
                  vi_ff        <= '0;
                  for (int i = 0; i < 4; i++) begin
                     for (int k = 0; k < 3; k++) begin
                        s_ff[i][k] <= (i == k + 1) ? $signed({1'b0, istep_ff}) : 32'sd0;
                     end
                  end
                  state_ff <= S_INIT;
               end
            end
            S_INIT: state_ff <= S_INIT_W;
            S_INIT_W: begin
               if (mrsp.done) begin
                  if (vi_ff == 3'd0) begin
                     m0_ff <= mrsp.merit;
                  end else begin
                     fv_ff[vi_ff[1:0] - 2'd1] <= mrsp.merit;
                  end
                  vi_ff    <= vi_ff + 3'd1;
                  state_ff <= (vi_ff == 3'd4) ? S_SORT : S_INIT;
               end
            end
            S_SORT: begin
               lo_ff  <= lo_c;
               hi_ff  <= hi_c;
               hi2_ff <= hi2_c;
               k_ff   <= '0;
               if (it_ff == limit_ff || (fv_ff[hi_c] - fv_ff[lo_c]) < tol_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_CEN_LD;
               end
            end
            S_CEN_LD: begin
               dn_ff    <= mag_c[32:0];
               dneg_ff  <= (sum_c < 0);
               state_ff <= S_CEN;
            end
            S_CEN: begin
               cen_ff[k_ff] <= sao_pkg::sat32(66'(cen_c));
               if (k_ff == 2'd2) begin
                  state_ff <= S_REF;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= S_CEN_LD;
               end
            end
            S_REF: state_ff <= S_REF_W;
            S_REF_W: begin
               if (mrsp.done) begin
                  fr_ff <= mrsp.merit;
                  if (mrsp.merit < fv_ff[lo_ff]) begin
                     state_ff <= S_EXP;
                  end else if (mrsp.merit < fv_ff[hi2_ff]) begin
                     for (int k = 0; k < 3; k++) s_ff[hi_ff][k] <= xr[k];
                     fv_ff[hi_ff] <= mrsp.merit;
                     it_ff        <= it_ff + 1'b1;
                     state_ff     <= S_SORT;
                  end else begin
                     state_ff <= S_CON;
                  end
               end
            end
            S_EXP: state_ff <= S_EXP_W;
            S_EXP_W: begin
               if (mrsp.done) begin
                  if (mrsp.merit < fr_ff) begin
                     for (int k = 0; k < 3; k++) s_ff[hi_ff][k] <= xe[k];
                     fv_ff[hi_ff] <= mrsp.merit;
                  end else begin
                     for (int k = 0; k < 3; k++) s_ff[hi_ff][k] <= xr[k];
                     fv_ff[hi_ff] <= fr_ff;
                  end
                  it_ff    <= it_ff + 1'b1;
                  state_ff <= S_SORT;
               end
            end
            S_CON: state_ff <= S_CON_W;
            S_CON_W: begin
               if (mrsp.done) begin
                  if (mrsp.merit < fv_ff[hi_ff]) begin
                     for (int k = 0; k < 3; k++) s_ff[hi_ff][k] <= xc[k];
                     fv_ff[hi_ff] <= mrsp.merit;
                     it_ff        <= it_ff + 1'b1;
                     state_ff     <= S_SORT;
                  end else begin
                     si_ff    <= '0;
                     state_ff <= S_SHR;
                  end
               end
            end
            S_SHR: begin
               // Pull every vertex but the best halfway toward the best one.
               if (si_ff == 3'd4) begin
                  it_ff    <= it_ff + 1'b1;
                  state_ff <= S_SORT;
               end else if (si_ff[1:0] == lo_ff) begin
                  si_ff <= si_ff + 3'd1;
               end else begin
                  for (int k = 0; k < 3; k++) s_ff[si_ff[1:0]][k] <= xs[k];
                  state_ff <= S_SHR_W;
               end
            end
            S_SHR_W: begin
               if (mrsp.done) begin
                  fv_ff[si_ff[1:0]] <= mrsp.merit;
                  si_ff             <= si_ff + 3'd1;
                  state_ff          <= S_SHR;
               end
            end
            S_OUT: begin
               // The best vertex is the lowest numbered one with minimal merit.
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_W'({(fv_ff[lo_c] < m0_ff), it_ff,
                                          s_ff[lo_c][2], s_ff[lo_c][1], s_ff[lo_c][0],
                                          fv_ff[lo_c], m0_ff});
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   // A merit evaluation is only launched when the unit is free.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mreq.start |-> !mrsp.busy)
      else $error("merit start while merit unit busy");

   // A merit result only arrives while the sequencer waits for one.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> (state_ff == S_INIT_W || state_ff == S_REF_W || state_ff == S_EXP_W
                     || state_ff == S_CON_W || state_ff == S_SHR_W))
      else $error("merit result outside a wait state");

   // The iteration count never passes the job's limit.
   a_iter_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (it_ff <= limit_ff))
      else $error("iteration count beyond limit");

   // Best and worst vertex differ once an iteration runs.
   a_lo_hi: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CEN) |-> (lo_ff != hi_ff && hi2_ff != hi_ff))
      else $error("best and worst vertex coincide");
`endif

endmodule

@@ tb/tb_simplex_alignment_optimizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simplex alignment optimizer testbench
// Sends alignment jobs under several register settings, predicts every search
// result in a fixed-point model of its own, and checks each response field.
// ----------------------------------------------------------------------------
module tb_simplex_alignment_optimizer;

   localparam int REQ_W = 144;
   localparam int RSP_W = 176;
   localparam int WATCHDOG_LIMIT = 2000000;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   // One alignment job as it travels on the request channel.
   typedef struct {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] tilt;
      logic signed [31:0] focus;
      logic [9:0]         limit;
   } job_item_type;

   // Response layout, highest field first so that merit_start lands in bit 0.
   typedef struct packed {
      logic [6:0]  pad;
      logic        improved;
      logic [9:0]  iters;
      logic [31:0] move_f;
      logic [31:0] move_y;
      logic [31:0] move_x;
      logic [30:0] best;
      logic [30:0] start;
   } outcome_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we = 1'b0;
   logic [sao_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [sao_pkg::CFG_BITS-1:0]       csr_data = '0;

   simplex_alignment_optimizer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copies of the lens registers, at their reset values.
   longint decenter_gain  = 65536;
   longint tilt_gain      = 65536;
   longint defocus_weight = 39322;
   longint stop_tolerance = 1;
   longint initial_step   = 1310720;

   job_item_type pending_jobs[$];
   outcome_type  expected_outcomes[$];
   int       failures = 0;
   int       quiet_cycles = 0;
   bit       steady = 1'b0;   // when set, neither side idles

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Fixed-point prediction of one search.
   // ------------------------------------------------------------------------
   function automatic longint clamp32(input longint v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
   endfunction

   // Floor square root, two bits per step.
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint unsigned square(input longint v);
      longint unsigned a;
      a = (v < 0) ? longint'(-v) : longint'(v);
      return a * a;
   endfunction

   // Spot merit of the move (mx, my, mf) for job j, saturated to 31 bits.
   function automatic longint spot_merit(input job_item_type j, input longint mx,
                                         input longint my, input longint mf);
      longint x, y, f, lx, ly, lf;
      longint unsigned r;
      x  = clamp32(longint'(j.ox) + mx);
      y  = clamp32(longint'(j.oy) + my);
      f  = clamp32(longint'(j.focus) + mf);
      lx = clamp32((decenter_gain * x + tilt_gain * longint'(j.tilt)) >>> 16);
      ly = clamp32((decenter_gain * y) >>> 16);
      lf = clamp32((defocus_weight * f) >>> 16);
      r  = floor_sqrt(square(lx) + square(ly) + square(lf));
      return (r > 64'h7fffffff) ? 64'h7fffffff : longint'(r);
   endfunction

   function automatic outcome_type predict_alignment(input job_item_type j);
      longint   s[4][3];
      longint   fv[4];
      longint   cen[3], xr[3], xe[3], xc[3];
      longint   m0, fr, fe, fc, sum;
      int       idx[4];
      int       lo, hi, hi2, b, best, it, t;
      outcome_type o;
      m0 = spot_merit(j, 0, 0, 0);
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++) s[i][k] = 0;
      for (int k = 0; k < 3; k++) s[k+1][k] = initial_step;
      for (int i = 0; i < 4; i++) fv[i] = spot_merit(j, s[i][0], s[i][1], s[i][2]);
      for (it = 0; it < int'(j.limit); it++) begin
         // Stable ordering: equal merits keep their vertex order.
         for (int i = 0; i < 4; i++) idx[i] = i;
         for (int a = 1; a < 4; a++) begin
            b = a;
            while (b > 0 && fv[idx[b]] < fv[idx[b-1]]) begin
               t = idx[b]; idx[b] = idx[b-1]; idx[b-1] = t;
               b--;
            end
         end
         lo = idx[0]; hi2 = idx[2]; hi = idx[3];
         // Converged: this does not count as an iteration.
         if (fv[hi] - fv[lo] < stop_tolerance) break;
         for (int k = 0; k < 3; k++) begin
            sum = 0;
            for (int i = 0; i < 4; i++) if (i != hi) sum += s[i][k];
            cen[k] = clamp32(sum / 3);   // truncates toward zero
            xr[k]  = clamp32(2 * cen[k] - s[hi][k]);
         end
         fr = spot_merit(j, xr[0], xr[1], xr[2]);
         if (fr < fv[lo]) begin
            for (int k = 0; k < 3; k++) xe[k] = clamp32(3 * cen[k] - 2 * s[hi][k]);
            fe = spot_merit(j, xe[0], xe[1], xe[2]);
            if (fe < fr) begin
               for (int k = 0; k < 3; k++) s[hi][k] = xe[k];
               fv[hi] = fe;
            end else begin
               for (int k = 0; k < 3; k++) s[hi][k] = xr[k];
               fv[hi] = fr;
            end
         end else if (fr < fv[hi2]) begin
            for (int k = 0; k < 3; k++) s[hi][k] = xr[k];
            fv[hi] = fr;
         end else begin
            for (int k = 0; k < 3; k++) xc[k] = (cen[k] + s[hi][k]) >>> 1;
            fc = spot_merit(j, xc[0], xc[1], xc[2]);
            if (fc < fv[hi]) begin
               for (int k = 0; k < 3; k++) s[hi][k] = xc[k];
               fv[hi] = fc;
            end else begin
               // Shrink every vertex halfway toward the best one.
               for (int i = 0; i < 4; i++)
                  if (i != lo) begin
                     for (int k = 0; k < 3; k++) s[i][k] = (s[lo][k] + s[i][k]) >>> 1;
                     fv[i] = spot_merit(j, s[i][0], s[i][1], s[i][2]);
                  end
            end
         end
      end
      best = 0;
      for (int i = 1; i < 4; i++) if (fv[i] < fv[best]) best = i;
      o          = '0;
      o.start    = m0[30:0];
      o.best     = fv[best][30:0];
      o.move_x   = s[best][0][31:0];
      o.move_y   = s[best][1][31:0];
      o.move_f   = s[best][2][31:0];
      o.iters    = it[9:0];
      o.improved = (fv[best] < m0);
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: holds a transaction until it is taken, otherwise offers
   // the next pending job unless it rolls an idle cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes = {expected_outcomes, predict_alignment(pending_jobs[0])};
            void'(pending_jobs.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_jobs.size() > 0 && (steady || $urandom_range(99) >= 38)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {6'b0, pending_jobs[0].limit, pending_jobs[0].focus,
                              pending_jobs[0].tilt, pending_jobs[0].oy, pending_jobs[0].ox};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: compares each transaction with the oldest prediction.
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_tdata);
               failures++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("merit_start", want.start, got.start);
               check_field("merit_best", want.best, got.best);
               check_field("move_x", want.move_x, got.move_x);
               check_field("move_y", want.move_y, got.move_y);
               check_field("move_focus", want.move_f, got.move_f);
               check_field("iterations_used", want.iters, got.iters);
               check_field("improved", want.improved, got.improved);
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 38);
      end
   end

   // The watchdog counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_simplex_alignment_optimizer: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic [sao_pkg::CSR_INDEX_BITS-1:0] idx,
                            input longint val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[30:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         sao_pkg::REG_DECENTER_GAIN:  decenter_gain  = val & 64'h7fffffff;
         sao_pkg::REG_TILT_GAIN:      tilt_gain      = val & 64'h7fffffff;
         sao_pkg::REG_DEFOCUS_WEIGHT: defocus_weight = val & 64'h7fffffff;
         sao_pkg::REG_STOP_TOLERANCE: stop_tolerance = val & 64'h7fffffff;
         sao_pkg::REG_INITIAL_STEP:   initial_step   = val & 64'h7fffffff;
         default: ;   // indexes past the last register are ignored
      endcase
   endtask

   task automatic write_all(input longint dg, input longint tg, input longint dw,
                            input longint tol, input longint st);
      write_reg(sao_pkg::REG_DECENTER_GAIN, dg);
      write_reg(sao_pkg::REG_TILT_GAIN, tg);
      write_reg(sao_pkg::REG_DEFOCUS_WEIGHT, dw);
      write_reg(sao_pkg::REG_STOP_TOLERANCE, tol);
      write_reg(sao_pkg::REG_INITIAL_STEP, st);
   endtask

   // Wait until every job has been answered; the block is then idle.
   task automatic drain();
      while (pending_jobs.size() != 0 || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic add_job(input logic [31:0] ox, input logic [31:0] oy,
                          input logic [31:0] tilt, input logic [31:0] focus,
                          input logic [9:0] limit);
      job_item_type j;
      j.ox = ox; j.oy = oy; j.tilt = tilt; j.focus = focus; j.limit = limit;
      pending_jobs = {pending_jobs, j};
   endtask

   // Coordinates: modest misalignments half the time, otherwise any value or an extreme.
   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'd26214400)) - 32'd13107200; // +-200.0
         2: return 32'($urandom_range(0, 32'd131072)) - 32'd65536;      // +-1.0
         default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      endcase
   endfunction

   // Most jobs stop early so the run stays short; a few search longer.
   task automatic add_random_jobs(input int count);
      for (int n = 0; n < count; n++)
         add_job(random_coord(), random_coord(), random_coord(), random_coord(),
                 ($urandom_range(19) == 0) ? 10'($urandom_range(13, 60))
                                           : 10'($urandom_range(0, 12)));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed jobs at the reset register values: field extremes, a zero
      // iteration limit, a job already aligned, and one full-length search.
      add_job(32'h0, 32'h0, 32'h0, 32'h0, 10'd0);
      add_job(32'h0, 32'h0, 32'h0, 32'h0, 10'd5);
      add_job(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 10'd3);
      add_job(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 10'd3);
      add_job(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 10'd0);
      add_job(32'h00140000, 32'hffec0000, 32'h00010000, 32'h000a0000, 10'd8);
      add_job(32'hfff00000, 32'h00030000, 32'hfffe0000, 32'hfffb0000, 10'd1);
      add_job(32'h00050000, 32'h00050000, 32'h0, 32'h00050000, 10'd1023);
      drain();

      // Largest gains, zero tolerance so the search never converges early,
      // and the widest initial simplex.
      write_all(64'h7fffffff, 64'h7fffffff, 64'h7fffffff, 0, 64'h7fffffff);
      add_job(32'h00010000, 32'hffff0000, 32'h00008000, 32'h00020000, 10'd4);
      add_job(32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff, 10'd6);
      add_job(32'h0, 32'h0, 32'h0, 32'h0, 10'd2);
      drain();

      // All gains zero, no initial step, largest tolerance: every merit is
      // zero and the search stops at once.
      write_all(0, 0, 0, 64'h7fffffff, 0);
      write_reg(3'd7, 64'h12345678);   // out of range index, no effect
      add_job(32'h12345678, 32'h9abcdef0, 32'h7fffffff, 32'h80000000, 10'd9);
      add_job(32'h0, 32'h0, 32'h0, 32'h0, 10'd1023);
      drain();

      // Random register settings with random jobs; one phase runs with no
      // idle cycles on either side.
      for (int phase = 0; phase < 4; phase++) begin
         write_all($urandom_range(0, 32'd262144), $urandom_range(0, 32'd262144),
                   $urandom_range(0, 32'd131072), $urandom_range(0, 32'd2048),
                   ($urandom_range(3) == 0) ? longint'($urandom) & 64'h7fffffff
                                            : longint'($urandom_range(0, 32'd6553600)));
         steady = (phase == 2);
         add_random_jobs(25);
         drain();
      end
      steady = 1'b0;

      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("tb_simplex_alignment_optimizer: PASS");
      end else begin
         $display("tb_simplex_alignment_optimizer: FAIL");
      end
      $finish;
   end

endmodule

@@ simplex_alignment_optimizer.f @@
hdl/sao_pkg.sv
hdl/sao_merit.sv
hdl/simplex_alignment_optimizer.sv
tb/tb_simplex_alignment_optimizer.sv
